[hw/rtl/prg_pkg.sv]
// ----------------------------------------------------------------------------
// prg_pkg
// Shared widths, codes and controller/datapath interface types for the
// piecewise-linear ramp generator.
// ----------------------------------------------------------------------------
package prg_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int SLOPE_W     = 48;
    localparam int NUM_W       = DATA_W + 1 + FRAC_W;
    localparam int PC_W        = 5;
    localparam int IDX_W       = 4;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic [DATA_W-1:0] CUR_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] CUR_MIN = 32'h8000_0000;

    typedef struct packed {
        logic take_tick;
        logic wr_entry;
        logic pi_inc;
        logic save_cur;
        logic rd_nb;
        logic seg_set;
        logic div_start;
        logic slope_ld;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic hit;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/piecewise_linear_ramp_generator_top.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_ramp_generator_top
// Piecewise-linear current ramp from a table of breakpoints.
//
// Input stream: tuser selects the beat kind. A write beat stores one
// breakpoint (time, amplitude) and restarts the segment index; it produces
// no output and leaves the block idle. A tick beat carries a step number and an
// active flag and produces exactly one output beat (current, sent).
// A tick first steps over every breakpoint already passed by its step. When the
// step is one before a breakpoint the segment is reloaded through the 49-bit
// bit-serial slope divider.
// The block takes one item at a time; a write may be accepted while a result
// still waits in the output register. A stalled receiver holds the result in
// that register and a further tick waits in its last step until it drains.
// APB register 0 (point_count) is to be written by the user with the block idle; the block does not enforce it.
// Reset clears the segment index, segment registers and point_count; the
// breakpoint tables are undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_ramp_generator_top #(
    parameter int MAX_POINTS = prg_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [31:0] step_number, [32] active, [36:33] entry_index,
    // [68:37] entry_time, [100:69] entry_value, [103:101] zero
    input  logic [prg_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [0] op
    input  logic                              i_s_tuser,
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [31:0] current, [32] sent, [39:33] zero
    output logic [prg_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // configuration
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [prg_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [prg_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [prg_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                              o_pready
);
    import prg_pkg::*;

    logic [PC_W-1:0]   r_point_count;
    logic              w_cfg_wr;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [DATA_W-1:0] w_current;
    logic              w_sent;

    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (w_cfg_wr && (i_paddr[2] == REG_POINT_COUNT)) begin
            r_point_count <= i_pwdata[PC_W-1:0];
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_POINT_COUNT: o_prdata = {{(APB_DATA_W-PC_W){1'b0}}, r_point_count};
            default:         o_prdata = '0;
        endcase
    end

    prg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    prg_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_point_count (r_point_count),
        .i_step_number (i_s_tdata[31:0]),
        .i_active      (i_s_tdata[32]),
        .i_entry_index (i_s_tdata[36:33]),
        .i_entry_time  (i_s_tdata[68:37]),
        .i_entry_value (i_s_tdata[100:69]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_current     (w_current),
        .o_sent        (w_sent)
    );

    assign o_m_tdata = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, w_sent, w_current};

endmodule

[hw/rtl/prg_div.sv]
// ----------------------------------------------------------------------------
// prg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [prg_pkg::NUM_W-1:0]     i_num,
    input  logic [prg_pkg::DATA_W-1:0]    i_den,
    output logic                          o_done,
    output logic [prg_pkg::NUM_W-1:0]     o_quot
);
    import prg_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quot;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;

    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hw/rtl/prg_dp.sv]
// ----------------------------------------------------------------------------
// prg_dp
// Datapath: breakpoint tables, segment registers, slope divider, ramp
// multiply pipeline and output register.
// ----------------------------------------------------------------------------
module prg_dp #(
    parameter int MAX_POINTS = prg_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prg_pkg::t_cmd                 i_cmd,
    output prg_pkg::t_sts                 o_sts,
    input  logic [prg_pkg::PC_W-1:0]      i_point_count,
    input  logic [prg_pkg::DATA_W-1:0]    i_step_number,
    input  logic                          i_active,
    input  logic [prg_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [prg_pkg::DATA_W-1:0]    i_entry_time,
    input  logic [prg_pkg::DATA_W-1:0]    i_entry_value,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [prg_pkg::DATA_W-1:0]    o_current,
    output logic                          o_sent
);
    import prg_pkg::*;

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PIW = $clog2(MAX_POINTS + 1);
    localparam int HI_W = SLOPE_W - 24;
    localparam int PR_W = 24 + DATA_W;
    localparam int P_W  = 34 + 24 + 1;
    localparam int Q_W  = P_W - FRAC_W;
    localparam int SUM_W = Q_W + 2;

    localparam logic [1:0] KIND_NEXT  = 2'd0;
    localparam logic [1:0] KIND_PREV  = 2'd1;
    localparam logic [1:0] KIND_FIRST = 2'd2;

    logic [DATA_W-1:0] time_mem  [MAX_POINTS];
    logic [DATA_W-1:0] value_mem [MAX_POINTS];

    logic [DATA_W-1:0]  r_rd_time;
    logic [DATA_W-1:0]  r_rd_value;
    logic [PIW-1:0]     r_pi;
    logic [DATA_W-1:0]  r_step;
    logic               r_active;
    logic [DATA_W-1:0]  r_ti;
    logic [DATA_W-1:0]  r_vi;
    logic [1:0]         r_kind;
    logic [AW-1:0]      r_nb_addr;
    logic [DATA_W-1:0]  r_start;
    logic [DATA_W-1:0]  r_amp;
    logic [SLOPE_W-1:0] r_slope;
    logic [DATA_W:0]    r_dv;
    logic [DATA_W-1:0]  r_dt;

    logic [SLOPE_W-1:0] r_ms;
    logic [DATA_W-1:0]  r_md;
    logic               r_neg0;
    logic [PR_W-1:0]    r_hm;
    logic [PR_W-1:0]    r_lo;
    logic               r_neg1;
    logic [Q_W-1:0]     r_q;
    logic               r_sat;
    logic               r_neg2;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_current;
    logic               r_sent;

    logic [PIW-1:0]     w_n;
    logic               w_pi_lt_n;
    logic [PIW:0]       w_pi_p1;
    logic [PIW-1:0]     w_pi_m1;
    logic               w_has_next;
    logic [1:0]         w_kind;
    logic [AW-1:0]      w_nb_addr;
    logic [AW-1:0]      w_rd_addr;
    logic [DATA_W:0]    w_step_p1;
    logic               w_wr_ok;

    logic [DATA_W-1:0]  w_seg_amp;
    logic [DATA_W-1:0]  w_seg_start;
    logic [DATA_W:0]    w_seg_dv;
    logic [DATA_W-1:0]  w_seg_dt;

    logic [DATA_W:0]    w_dv_mag;
    logic [NUM_W-1:0]   w_num;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quot;
    logic [SLOPE_W-1:0] w_slope;

    logic [DATA_W:0]    w_delta;
    logic [DATA_W:0]    w_delta_neg;
    logic [P_W-1:0]     w_p;
    logic [SUM_W-1:0]   w_amp_x;
    logic [SUM_W-1:0]   w_q_x;
    logic [SUM_W-1:0]   w_sum;
    logic               w_ovf;
    logic [DATA_W-1:0]  w_ramp;

    // ------------------------------------------------------------------ index
    assign w_n = (32'(i_point_count) > 32'(MAX_POINTS)) ? PIW'(MAX_POINTS)
                                                        : PIW'(i_point_count);
    assign w_pi_lt_n  = r_pi < w_n;
    assign w_pi_p1    = {1'b0, r_pi} + {{PIW{1'b0}}, 1'b1};
    assign w_pi_m1    = r_pi - {{(PIW-1){1'b0}}, 1'b1};
    assign w_has_next = w_pi_p1 < {1'b0, w_n};
    assign w_kind     = w_has_next ? KIND_NEXT : ((r_pi != '0) ? KIND_PREV : KIND_FIRST);

    always_comb begin
        case (w_kind)
            KIND_NEXT: w_nb_addr = w_pi_p1[AW-1:0];
            KIND_PREV: w_nb_addr = w_pi_m1[AW-1:0];
            default:   w_nb_addr = r_pi[AW-1:0];
        endcase
    end

    assign w_rd_addr = i_cmd.rd_nb ? r_nb_addr : r_pi[AW-1:0];
    assign w_wr_ok   = 32'(i_entry_index) < 32'(MAX_POINTS);
    assign w_step_p1 = {1'b0, r_step} + {{DATA_W{1'b0}}, 1'b1};

    // ----------------------------------------------------------------- tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && w_wr_ok) begin
            time_mem[AW'(i_entry_index)]  <= i_entry_time;
            value_mem[AW'(i_entry_index)] <= i_entry_value;
        end
        r_rd_time  <= time_mem[w_rd_addr];
        r_rd_value <= value_mem[w_rd_addr];
    end

    // ---------------------------------------------------------- segment setup
    always_comb begin
        case (r_kind)
            KIND_NEXT: begin
                w_seg_amp   = r_vi;
                w_seg_start = r_ti;
                w_seg_dv    = {r_rd_value[DATA_W-1], r_rd_value} - {r_vi[DATA_W-1], r_vi};
                w_seg_dt    = r_rd_time - r_ti;
            end
            KIND_PREV: begin
                w_seg_amp   = r_rd_value;
                w_seg_start = r_rd_time;
                w_seg_dv    = {r_vi[DATA_W-1], r_vi} - {r_rd_value[DATA_W-1], r_rd_value};
                w_seg_dt    = r_ti - r_rd_time;
            end
            default: begin
                // single point: ramp from zero at step zero
                w_seg_amp   = '0;
                w_seg_start = '0;
                w_seg_dv    = {r_vi[DATA_W-1], r_vi};
                w_seg_dt    = r_ti;
            end
        endcase
    end

    assign w_dv_mag = r_dv[DATA_W] ? ({(DATA_W+1){1'b0}} - r_dv) : r_dv;
    assign w_num    = {w_dv_mag, {FRAC_W{1'b0}}};

    prg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_dt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // saturate quotient to signed 48 bits
    always_comb begin
        if (r_dt == '0) begin
            w_slope = '0;
        end else if (r_dv[DATA_W]) begin
            if (|w_quot[NUM_W-1:SLOPE_W-1]) begin
                w_slope = {1'b1, {(SLOPE_W-1){1'b0}}};
            end else begin
                w_slope = {SLOPE_W{1'b0}} - w_quot[SLOPE_W-1:0];
            end
        end else begin
            if (|w_quot[NUM_W-1:SLOPE_W-1]) begin
                w_slope = {1'b0, {(SLOPE_W-1){1'b1}}};
            end else begin
                w_slope = w_quot[SLOPE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pi    <= '0;
            r_start <= '0;
            r_amp   <= '0;
            r_slope <= '0;
        end else begin
            if (i_cmd.wr_entry) begin
                r_pi <= '0;
            end else if (i_cmd.pi_inc) begin
                r_pi <= w_pi_p1[PIW-1:0];
            end
            if (i_cmd.seg_set) begin
                r_start <= w_seg_start;
                r_amp   <= w_seg_amp;
            end
            if (i_cmd.slope_ld) begin
                r_slope <= w_slope;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_tick) begin
            r_step   <= i_step_number;
            r_active <= i_active;
        end
        if (i_cmd.save_cur) begin
            r_ti      <= r_rd_time;
            r_vi      <= r_rd_value;
            r_kind    <= w_kind;
            r_nb_addr <= w_nb_addr;
        end
        if (i_cmd.seg_set) begin
            r_dv <= w_seg_dv;
            r_dt <= w_seg_dt;
        end
    end

    // ------------------------------------------------------------ ramp pipe
    assign w_delta     = {1'b0, r_step} - {1'b0, r_start};
    assign w_delta_neg = {(DATA_W+1){1'b0}} - w_delta;
    assign w_p         = {1'b0, r_hm[33:0], 24'b0} + {3'b0, r_lo};

    always_ff @(posedge i_clk) begin
        r_ms   <= r_slope[SLOPE_W-1] ? ({SLOPE_W{1'b0}} - r_slope) : r_slope;
        r_md   <= w_delta[DATA_W] ? w_delta_neg[DATA_W-1:0] : w_delta[DATA_W-1:0];
        r_neg0 <= r_slope[SLOPE_W-1] ^ w_delta[DATA_W];

        r_hm   <= r_ms[SLOPE_W-1:24] * r_md;
        r_lo   <= r_ms[23:0] * r_md;
        r_neg1 <= r_neg0;

        r_sat  <= |r_hm[PR_W-1:34];
        r_q    <= w_p[P_W-1:FRAC_W];
        r_neg2 <= r_neg1;
    end

    assign w_amp_x = {{(SUM_W-DATA_W){r_amp[DATA_W-1]}}, r_amp};
    assign w_q_x   = {2'b0, r_q};
    assign w_sum   = r_neg2 ? (w_amp_x - w_q_x) : (w_amp_x + w_q_x);
    assign w_ovf   = !((&w_sum[SUM_W-1:DATA_W-1]) || !(|w_sum[SUM_W-1:DATA_W-1]));

    always_comb begin
        if (r_sat) begin
            w_ramp = r_neg2 ? CUR_MIN : CUR_MAX;
        end else if (w_ovf) begin
            w_ramp = w_sum[SUM_W-1] ? CUR_MIN : CUR_MAX;
        end else begin
            w_ramp = w_sum[DATA_W-1:0];
        end
    end

    // ----------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_current <= r_active ? w_ramp : '0;
            r_sent    <= r_active;
        end
    end

    assign o_sts.skip     = w_pi_lt_n && (r_rd_time <= r_step);
    assign o_sts.hit      = w_pi_lt_n && (w_step_p1 == {1'b0, r_rd_time});
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_current  = r_current;
    assign o_sent     = r_sent;

endmodule

[hw/rtl/prg_ctrl.sv]
// ----------------------------------------------------------------------------
// prg_ctrl
// Sequencer: skips passed breakpoints, loads a segment when due, runs the
// slope division and the ramp pipeline, hands the result to the output.
// ----------------------------------------------------------------------------
module prg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_op,
    output logic          o_s_tready,
    output prg_pkg::t_cmd o_cmd,
    input  prg_pkg::t_sts i_sts
);
    import prg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_NRD  = 4'd3;
    localparam logic [3:0] S_SEG  = 4'd4;
    localparam logic [3:0] S_DIVS = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_ABS  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_op == OP_WRITE) begin
                        o_cmd.wr_entry = 1'b1;
                    end else begin
                        o_cmd.take_tick = 1'b1;
                        n_state         = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.skip) begin
                    o_cmd.pi_inc = 1'b1;
                    n_state      = S_RD;
                end else if (i_sts.hit) begin
                    o_cmd.save_cur = 1'b1;
                    n_state        = S_NRD;
                end else begin
                    n_state = S_ABS;
                end
            end
            S_NRD: begin
                o_cmd.rd_nb = 1'b1;
                n_state     = S_SEG;
            end
            S_SEG: begin
                o_cmd.seg_set = 1'b1;
                o_cmd.pi_inc  = 1'b1;
                n_state       = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.slope_ld = 1'b1;
                    n_state        = S_ABS;
                end
            end
            S_ABS: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait for room in the output register
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/prg_chk.sv]
// ----------------------------------------------------------------------------
// prg_chk
// Port-level checks for the ramp generator, bound to the top level.
// ----------------------------------------------------------------------------
module prg_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [prg_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import prg_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat changed while stalled");

    // inactive tick reports zero current
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[32] |-> o_m_tdata[31:0] == '0)
        else $error("nonzero current with sent low");

    // an accepted tick beat leaves the block busy, with ready low
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_TICK) |=> !o_s_tready)
        else $error("ready right after a tick beat");

    // a table write creates no result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_WRITE) |=> !$rose(o_m_tvalid))
        else $error("result after a write beat");

endmodule

bind piecewise_linear_ramp_generator_top prg_chk u_prg_chk (.*);

[tb/prg_ramp_checker.sv]
// ----------------------------------------------------------------------------
// prg_ramp_checker
// Watches the input stream, the output stream and the register port of the
// ramp generator. Keeps its own copy of the breakpoint tables and of the
// segment registers, predicts the current for every accepted tick beat and
// compares each output beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module prg_ramp_checker
    import prg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                    i_s_tuser,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [OUT_TDATA_W-1:0]  i_m_tdata,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [APB_ADDR_W-1:0]   i_paddr,
    input  logic [APB_DATA_W-1:0]   i_pwdata,
    input  logic                    i_pready,
    output int                      o_mismatches,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SLOPE_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] SLOPE_NEG_MAG = 64'h0000_8000_0000_0000;
    localparam logic [SLOPE_W-1:0] SLOPE_MOST_POS = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MOST_NEG = {1'b1, {(SLOPE_W-1){1'b0}}};
    localparam longint AMP_HI = 64'sd2147483647;
    localparam longint AMP_LO = -64'sd2147483648;

    typedef struct packed {
        logic              sent;
        logic [DATA_W-1:0] current;
    } ramp_result_t;

    logic [DATA_W-1:0]         time_tab [MAX_POINTS];
    logic [DATA_W-1:0]         value_tab [MAX_POINTS];
    int unsigned               point_index;
    logic [PC_W-1:0]           point_count;
    logic [DATA_W-1:0]         seg_start;
    logic signed [DATA_W-1:0]  seg_amp;
    logic signed [SLOPE_W-1:0] seg_slope;

    ramp_result_t expected_currents [$];
    ramp_result_t want;
    ramp_result_t got;

    // Q32.16 slope, truncated toward zero and clamped to 48 bits
    function automatic logic signed [SLOPE_W-1:0] slope_of(longint rise,
                                                           logic [DATA_W-1:0] run);
        logic [63:0] mag;
        logic [63:0] quo;
        if (run == '0) begin
            return '0;
        end
        mag = rise[63] ? 64'(-rise) : 64'(rise);
        quo = (mag << FRAC_W) / {32'd0, run};
        if (rise[63]) begin
            return (quo >= SLOPE_NEG_MAG) ? SLOPE_MOST_NEG : -quo[SLOPE_W-1:0];
        end
        return (quo > SLOPE_POS_MAX) ? SLOPE_MOST_POS : quo[SLOPE_W-1:0];
    endfunction

    function automatic void load_segment(int unsigned from_pt, int unsigned to_pt);
        seg_amp   = value_tab[from_pt];
        seg_start = time_tab[from_pt];
        seg_slope = slope_of(longint'($signed(value_tab[to_pt]))
                             - longint'($signed(value_tab[from_pt])),
                             time_tab[to_pt] - time_tab[from_pt]);
    endfunction

    function automatic logic [DATA_W-1:0] ramp_at(logic [DATA_W-1:0] step);
        longint       offset;
        longint       sum;
        logic [63:0]  mag_slope;
        logic [63:0]  mag_off;
        logic [127:0] scaled;
        logic         neg;
        offset    = longint'({32'd0, step}) - longint'({32'd0, seg_start});
        neg       = seg_slope[SLOPE_W-1] ^ offset[63];
        mag_slope = seg_slope[SLOPE_W-1] ? 64'd0 - {{16{1'b1}}, seg_slope}
                                         : {16'd0, seg_slope};
        mag_off   = offset[63] ? 64'(-offset) : 64'(offset);
        scaled    = ({64'd0, mag_slope} * {64'd0, mag_off}) >> FRAC_W;
        if (scaled >= (128'd1 << 33)) begin
            return neg ? CUR_MIN : CUR_MAX;
        end
        sum = longint'(seg_amp) + (neg ? -longint'(scaled[63:0]) : longint'(scaled[63:0]));
        if (sum > AMP_HI) begin
            return CUR_MAX;
        end
        if (sum < AMP_LO) begin
            return CUR_MIN;
        end
        return sum[DATA_W-1:0];
    endfunction

    function automatic ramp_result_t predict_tick(logic [DATA_W-1:0] step, logic active);
        int unsigned  in_use;
        int unsigned  i;
        ramp_result_t res;
        in_use = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
        // pass every breakpoint already reached
        while (point_index < in_use && time_tab[point_index] <= step) begin
            point_index++;
        end
        i = point_index;
        // one step before the next breakpoint: reload the segment
        if (i < in_use && ({1'b0, step} + 33'd1) == {1'b0, time_tab[i]}) begin
            if (i + 1 < in_use) begin
                load_segment(i, i + 1);
            end else if (i >= 1) begin
                load_segment(i - 1, i);
            end else begin
                // lone point: ramp from zero at step zero
                seg_amp   = '0;
                seg_start = '0;
                seg_slope = slope_of(longint'($signed(value_tab[0])), time_tab[0]);
            end
            point_index++;
        end
        res.sent    = active;
        res.current = active ? ramp_at(step) : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_index  = 0;
            point_count  = '0;
            seg_start    = '0;
            seg_amp      = '0;
            seg_slope    = '0;
            o_mismatches = 0;
            expected_currents.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[2] == REG_POINT_COUNT) begin
                point_count = i_pwdata[PC_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_WRITE) begin
                    if (i_s_tdata[36:33] < MAX_POINTS) begin
                        time_tab[i_s_tdata[36:33]]  = i_s_tdata[68:37];
                        value_tab[i_s_tdata[36:33]] = i_s_tdata[100:69];
                    end
                    point_index = 0;
                end else begin
                    expected_currents.push_back(predict_tick(i_s_tdata[31:0],
                                                             i_s_tdata[32]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.current = i_m_tdata[31:0];
                got.sent    = i_m_tdata[32];
                if (expected_currents.size() == 0) begin
                    $display("%0t unexpected output beat: current %h sent %b",
                             $time, got.current, got.sent);
                    o_mismatches++;
                end else begin
                    want = expected_currents.pop_front();
                    if (got.current !== want.current) begin
                        $display("%0t current mismatch: expected %h got %h",
                                 $time, want.current, got.current);
                        o_mismatches++;
                    end
                    if (got.sent !== want.sent) begin
                        $display("%0t sent mismatch: expected %b got %b",
                                 $time, want.sent, got.sent);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = expected_currents.size();
    end

endmodule

[tb/piecewise_linear_ramp_generator_top_tb.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_ramp_generator_top_tb
// Drives breakpoint tables, point counts and tick sequences into the ramp
// generator: a directed pass over saturation, zero-length segments, wrapped
// times, a lone point and the last step, then random waveforms swept one step
// at a time with some noise. Both stream sides idle at random in phases; the
// checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
module piecewise_linear_ramp_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prg_pkg::*;

    localparam int RANDOM_ITEMS  = 550;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tuser = OP_TICK;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_psel = 1'b0;
    logic                   i_penable = 1'b0;
    logic                   i_pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  i_paddr = '0;
    logic [APB_DATA_W-1:0]  i_pwdata = '0;
    logic [APB_DATA_W-1:0]  o_prdata;
    logic                   o_pready;

    int mismatches;
    int pending;
    int items;
    int directed_items;
    int rx_beats;
    int idle_phase;
    bit held;

    piecewise_linear_ramp_generator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    prg_ramp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_psel       (i_psel),
        .i_penable    (i_penable),
        .i_pwrite     (i_pwrite),
        .i_paddr      (i_paddr),
        .i_pwdata     (i_pwdata),
        .i_pready     (o_pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t timeout with %0d results outstanding", $time, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // phases: none, sender idle, receiver stall, both, none
    function automatic int sender_idle_pct();
        return (idle_phase == 1) ? 47 : (idle_phase == 3) ? 35 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (idle_phase == 2) ? 47 : (idle_phase == 3) ? 35 : 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rx_beats <= rx_beats + 1;
        end
    end

    initial begin
        rx_beats = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            // one long hold so the block fills up and back-pressures its input
            if (!held && rx_beats >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    function automatic logic [IN_TDATA_W-1:0] tick_beat(logic [31:0] step, logic active);
        return {3'd0, 32'd0, 32'd0, 4'd0, active, step};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] entry_beat(logic [IDX_W-1:0] idx,
                                                         logic [31:0] t, logic [31:0] v);
        return {3'd0, v, t, idx, 1'b0, 32'd0};
    endfunction

    function automatic logic [31:0] pick_amplitude();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: return r;
            1: return r[0] ? CUR_MAX : CUR_MIN;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        logic [31:0] t;
        t = $urandom;
        return (t == '0) ? 32'd1 : t;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input logic op, input logic [IN_TDATA_W-1:0] beat);
        if ($urandom_range(99) < sender_idle_pct()) begin
            i_s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < sender_idle_pct());
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= beat;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        items++;
    endtask

    task automatic send_tick(input logic [31:0] step, input logic active);
        offer(OP_TICK, tick_beat(step, active));
    endtask

    task automatic send_entry(input logic [IDX_W-1:0] idx, input logic [31:0] t,
                              input logic [31:0] v);
        offer(OP_WRITE, entry_beat(idx, t, v));
    endtask

    // drain every result, then give the last beat time to finish
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_point_count(input int unsigned count);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {REG_POINT_COUNT, 2'b00};
        i_pwdata  <= APB_DATA_W'(count);
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // one random waveform: table written in order, then a step-by-step sweep
    task automatic play_waveform(input bit full_table);
        logic [31:0] times [16];
        logic [31:0] step;
        int unsigned count;
        int unsigned pick;
        int unsigned ticks;
        int k;
        settle();
        idle_phase <= ((items - directed_items) / ITEMS_PER_PHASE) % 5;
        pick = $urandom_range(9);
        if (full_table || pick == 0) begin
            count = MAX_POINTS_DEF;
        end else if (pick == 1) begin
            count = 0;
        end else if (pick == 2) begin
            count = 1;
        end else begin
            count = $urandom_range(2, 7);
        end
        program_point_count(count);
        pick = $urandom_range(9);
        times[0] = (pick == 0) ? 32'hFFFF_FFC0 + $urandom_range(63)
                 : (pick < 3) ? 32'($urandom_range(1, 6)) : pick_time();
        for (k = 1; k < 16; k++) begin
            // mostly rising times, now and then a scrambled table
            times[k] = (pick == 9) ? pick_time() : times[k-1] + $urandom_range(1, 6);
            if (times[k] == '0) begin
                times[k] = 32'd1;
            end
        end
        for (k = 0; k < count; k++) begin
            send_entry(IDX_W'(k), times[k], pick_amplitude());
        end
        step  = (count > 0) ? times[0] - $urandom_range(1, 3) : $urandom;
        ticks = $urandom_range(6, 28);
        repeat (ticks) begin
            pick = $urandom_range(24);
            if (pick == 0) begin
                send_entry(IDX_W'($urandom_range(15)), pick_time(), pick_amplitude());
            end else if (pick == 1) begin
                send_tick($urandom, $urandom_range(1));
            end else begin
                send_tick(step, $urandom_range(9) != 0);
                step = step + (($urandom_range(4) == 0) ? $urandom_range(2, 5) : 1);
            end
        end
    endtask

    initial begin
        items = 0;
        directed_items = 0;
        idle_phase = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table
        program_point_count(0);
        send_tick(32'd0, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b0);

        // lone point, ramp from zero and past it
        settle();
        program_point_count(1);
        send_entry(4'd0, 32'd5, CUR_MAX);
        send_tick(32'd4, 1'b1);
        send_tick(32'd5, 1'b1);
        send_tick(32'd9, 1'b1);

        // full-scale rise in one step: slope clamps, last segment reused
        settle();
        program_point_count(2);
        send_entry(4'd0, 32'd10, CUR_MIN);
        send_entry(4'd1, 32'd11, CUR_MAX);
        send_tick(32'd9, 1'b1);
        send_tick(32'd10, 1'b1);
        send_tick(32'd12, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b1);

        // times going backward, equal times, negative clamp
        settle();
        program_point_count(3);
        send_entry(4'd0, 32'd40, 32'd0);
        send_entry(4'd1, 32'd38, CUR_MIN);
        send_entry(4'd2, 32'd38, CUR_MAX);
        send_tick(32'd39, 1'b1);
        send_tick(32'd41, 1'b1);
        send_entry(4'd0, 32'd37, 32'd0);
        send_tick(32'd36, 1'b1);
        send_tick(32'd37, 1'b1);
        send_tick(32'd38, 1'b1);
        send_tick(32'd39, 1'b0);
        directed_items = items;

        play_waveform(1'b1);
        while (items < directed_items + RANDOM_ITEMS) begin
            play_waveform(1'b0);
        end

        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
